@@ rtl/corner_bspline_points_assert.svh @@
// assertion macros used by the port-level checker file
`ifndef CORNER_BSPLINE_POINTS_ASSERT_SVH
`define CORNER_BSPLINE_POINTS_ASSERT_SVH

// same-cycle implication, consequent may open with a fixed delay
`define CBSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error(msg);

// next-cycle implication
`define CBSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cbsp_pkg.sv @@
// constants, weight tables and types for the corner b-spline point generator
package cbsp_pkg;

	localparam int STEPS   = 10;
	localparam int FAC     = 1000;
	localparam int SEGS    = 3;
	localparam int POINTS  = SEGS * STEPS + 1;
	localparam int STEP_W  = $clog2(STEPS);
	localparam int SEG_W   = $clog2(SEGS);

	localparam int COORD_W = 16;
	localparam int CTL_W   = COORD_W + 2;
	localparam int WGT_W   = 10;
	localparam int PROD_W  = CTL_W + WGT_W + 1;
	localparam int SUM_W   = PROD_W + 2;

	// divide by 4*FAC = 32*125: shift by 5, then reciprocal multiply by 1/125
	localparam int HALF       = 2 * FAC;
	localparam int PRE_SHIFT  = 5;
	localparam int DIV_REST   = (4 * FAC) >> PRE_SHIFT;
	localparam int OFFSET     = DIV_REST * (1 << COORD_W);
	localparam int Y_W        = 24;
	localparam int RECIP_SHIFT = 31;
	localparam int RECIP_W    = 25;
	localparam int PRODQ_W    = Y_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_REST) - 64'd1) / 64'(DIV_REST));

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [CTL_W-1:0]   ctl_t;
	typedef logic [WGT_W-1:0]          wgt_t;
	typedef wgt_t [STEPS-1:0]          wtab_t;
	typedef logic [STEP_W-1:0]         step_t;
	typedef logic [SEG_W-1:0]          seg_t;

	typedef struct packed {
		logic  valid;
		logic  last;
		seg_t  seg;
		step_t step;
	} issue_t;

	function automatic wtab_t build_t1();
		wtab_t tab;
		int    w;
		for (int j = 0; j < STEPS; j++) begin
			w = FAC * j / STEPS;
			tab[j] = WGT_W'(w * w / (2 * FAC));
		end
		return tab;
	endfunction

	function automatic wtab_t build_t2();
		wtab_t tab;
		int    u;
		for (int j = 0; j < STEPS; j++) begin
			u = FAC * j / STEPS - FAC / 2;
			tab[j] = WGT_W'(3 * FAC / 4 - u * u / FAC);
		end
		return tab;
	endfunction

	function automatic wtab_t build_t3();
		wtab_t tab;
		int    v;
		for (int j = 0; j < STEPS; j++) begin
			v = FAC * j / STEPS - FAC;
			tab[j] = WGT_W'(v * v / (2 * FAC));
		end
		return tab;
	endfunction

	localparam wtab_t T1 = build_t1();
	localparam wtab_t T2 = build_t2();
	localparam wtab_t T3 = build_t3();

endpackage

@@ rtl/cbsp_eval.sv @@
// three-stage evaluation pipeline: weighted products, rounding prep, reciprocal divide
module cbsp_eval (
	input  logic            clk,
	input  logic            arst_n,
	input  cbsp_pkg::issue_t issue,
	input  cbsp_pkg::ctl_t  p1x,
	input  cbsp_pkg::ctl_t  mx,
	input  cbsp_pkg::ctl_t  p3x,
	input  cbsp_pkg::ctl_t  p1y,
	input  cbsp_pkg::ctl_t  my,
	input  cbsp_pkg::ctl_t  p3y,
	output cbsp_pkg::coord_t point_x,
	output cbsp_pkg::coord_t point_y,
	output logic            last_point,
	output logic            point_valid
);
	import cbsp_pkg::*;

	typedef logic signed [PROD_W-1:0] prod_t;

	ctl_t  ax, bx, cx, ay, by, cy;
	wgt_t  w1, w2, w3;
	prod_t prod_x_s1 [3];
	prod_t prod_y_s1 [3];
	logic  valid_s1, last_s1;
	logic [Y_W-1:0] yx_s2, yy_s2;
	logic  valid_s2, last_s2;
	logic [PRODQ_W-1:0] qx, qy;

	function automatic prod_t wmul(ctl_t c, wgt_t w);
		return PROD_W'(c) * PROD_W'($signed({1'b0, w}));
	endfunction

	// add half, floor by 32, then bias so the divide by 125 sees a nonnegative value
	function automatic logic [Y_W-1:0] pre_round(prod_t a, prod_t b, prod_t c);
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] shr;
		sum = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(HALF);
		shr = sum >>> PRE_SHIFT;
		return Y_W'(shr + SUM_W'(OFFSET));
	endfunction

	// control points C[seg], C[seg+1], C[seg+2] of the sequence P1 P1 M P3 P3
	always_comb begin
		case (issue.seg)
			SEG_W'(0): begin
				ax = p1x; bx = p1x; cx = mx;
				ay = p1y; by = p1y; cy = my;
			end
			SEG_W'(1): begin
				ax = p1x; bx = mx; cx = p3x;
				ay = p1y; by = my; cy = p3y;
			end
			default: begin
				ax = mx; bx = p3x; cx = p3x;
				ay = my; by = p3y; cy = p3y;
			end
		endcase
		w1 = T1[issue.step];
		w2 = T2[issue.step];
		w3 = T3[issue.step];
	end

	always_ff @(posedge clk) begin
		prod_x_s1[0] <= wmul(ax, w3);
		prod_x_s1[1] <= wmul(bx, w2);
		prod_x_s1[2] <= wmul(cx, w1);
		prod_y_s1[0] <= wmul(ay, w3);
		prod_y_s1[1] <= wmul(by, w2);
		prod_y_s1[2] <= wmul(cy, w1);
		last_s1 <= issue.last;
		yx_s2 <= pre_round(prod_x_s1[0], prod_x_s1[1], prod_x_s1[2]);
		yy_s2 <= pre_round(prod_y_s1[0], prod_y_s1[1], prod_y_s1[2]);
		last_s2 <= last_s1;
	end

	assign qx = PRODQ_W'(yx_s2) * PRODQ_W'(RECIP);
	assign qy = PRODQ_W'(yy_s2) * PRODQ_W'(RECIP);

	// low bits of the biased quotient are the signed result
	always_ff @(posedge clk) begin
		point_x <= qx[RECIP_SHIFT +: COORD_W];
		point_y <= qy[RECIP_SHIFT +: COORD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			point_valid <= 1'b0;
			last_point  <= 1'b0;
		end else begin
			valid_s1    <= issue.valid;
			valid_s2    <= valid_s1;
			point_valid <= valid_s2;
			last_point  <= valid_s2 & last_s2;
		end
	end

endmodule

@@ rtl/corner_bspline_points.sv @@
// corner rounding: 31 quadratic b-spline points per item, start point first
// first point passes the product, rounding and divide registers; then one point per cycle
// items: the single point sequencer issues all points of an item before it takes the next; busy drops
//   during the last issue cycle so the next item follows without a gap
// reset: arst_n clears the sequencer and pipeline valids; the receiver cannot stall
module corner_bspline_points (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cbsp_pkg::coord_t start_x,
	input  cbsp_pkg::coord_t start_y,
	input  cbsp_pkg::coord_t corner_x,
	input  cbsp_pkg::coord_t corner_y,
	input  cbsp_pkg::coord_t end_x,
	input  cbsp_pkg::coord_t end_y,
	output cbsp_pkg::coord_t point_x,
	output cbsp_pkg::coord_t point_y,
	output logic             last_point,
	output logic             point_valid
);
	import cbsp_pkg::*;

	ctl_t   p1x_q, mx_q, p3x_q, p1y_q, my_q, p3y_q;
	logic   active_q, first_q;
	seg_t   seg_q;
	step_t  step_q;
	logic   cmd_accept, last_issue;
	issue_t issue;

	assign last_issue = active_q && !first_q && seg_q == SEG_W'(SEGS - 1)
		&& step_q == STEP_W'(STEPS - 1);
	assign busy       = active_q && !last_issue;
	assign cmd_accept = start && !busy;

	// control points in quarter units
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			p1x_q <= CTL_W'(start_x) <<< 2;
			p1y_q <= CTL_W'(start_y) <<< 2;
			p3x_q <= CTL_W'(end_x) <<< 2;
			p3y_q <= CTL_W'(end_y) <<< 2;
			mx_q  <= CTL_W'(start_x) + (CTL_W'(corner_x) <<< 1) + CTL_W'(end_x);
			my_q  <= CTL_W'(start_y) + (CTL_W'(corner_y) <<< 1) + CTL_W'(end_y);
		end
	end

	// first issue repeats segment 0 step 0, which lands exactly on the start point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			first_q  <= 1'b0;
			seg_q    <= '0;
			step_q   <= '0;
		end else if (cmd_accept) begin
			active_q <= 1'b1;
			first_q  <= 1'b1;
			seg_q    <= '0;
			step_q   <= '0;
		end else if (active_q) begin
			if (first_q) begin
				first_q <= 1'b0;
			end else if (step_q == STEP_W'(STEPS - 1)) begin
				step_q <= '0;
				if (seg_q == SEG_W'(SEGS - 1)) begin
					active_q <= 1'b0;
					seg_q    <= '0;
				end else begin
					seg_q <= seg_q + SEG_W'(1);
				end
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_comb begin
		issue.valid = active_q;
		issue.last  = last_issue;
		issue.seg   = seg_q;
		issue.step  = step_q;
	end

	cbsp_eval u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (issue),
		.p1x         (p1x_q),
		.mx          (mx_q),
		.p3x         (p3x_q),
		.p1y         (p1y_q),
		.my          (my_q),
		.p3y         (p3y_q),
		.point_x     (point_x),
		.point_y     (point_y),
		.last_point  (last_point),
		.point_valid (point_valid)
	);

endmodule

@@ rtl/cbsp_checker.sv @@
// port-level checker for the corner b-spline point generator, with its bind
module cbsp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input cbsp_pkg::coord_t start_x,
	input cbsp_pkg::coord_t start_y,
	input cbsp_pkg::coord_t corner_x,
	input cbsp_pkg::coord_t corner_y,
	input cbsp_pkg::coord_t end_x,
	input cbsp_pkg::coord_t end_y,
	input cbsp_pkg::coord_t point_x,
	input cbsp_pkg::coord_t point_y,
	input logic             last_point,
	input logic             point_valid
);
	`include "corner_bspline_points_assert.svh"

	logic item_acc;
	logic unused_ok;

	assign item_acc  = start && !busy;
	assign unused_ok = ^{corner_x, corner_y, end_x, end_y};

	`CBSP_ASSERT_IMP(a_last_has_strobe, clk, arst_n, last_point, point_valid, "last flag without strobe")
	`CBSP_ASSERT_NXT(a_busy_after_accept, clk, arst_n, item_acc, busy, "not busy after an accepted item")
	`CBSP_ASSERT_IMP(a_first_is_start, clk, arst_n, item_acc, ##4 (point_valid && !last_point && point_x == $past(start_x, 4) && point_y == $past(start_y, 4) && (unused_ok || !unused_ok)), "first point is not the start point")
	`CBSP_ASSERT_IMP(a_last_follows_busy, clk, arst_n, $fell(busy), ##3 (point_valid && last_point), "final point missing after busy fell")

endmodule

bind corner_bspline_points cbsp_checker u_cbsp_checker (.*);
